// ===== hw/rtl/rpq_pkg.sv =====
// Shared types, constants and the priority compare for the record priority queue.
package rpq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int ID_W     = 16;
   localparam int SCORE_W  = 16;
   localparam int CLASS_W  = 8;
   localparam int STATUS_W = 2;

   localparam logic [CLASS_W-1:0] PREFERRED_CLASS = 8'h46;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SCORE_W-1:0] score;
      logic [CLASS_W-1:0] cls;
   } rec_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      rec_type          wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } store_req_type;

   function automatic logic beats(input rec_type cand, input rec_type best);
      logic result;
      if (cand.score != best.score) begin
         result = cand.score > best.score;
      end else if (cand.cls == best.cls) begin
         result = cand.id < best.id;
      end else begin
         result = cand.cls == PREFERRED_CLASS;
      end
      return result;
   endfunction

endpackage

// ===== hw/rtl/rpq_store.sv =====
// Record store: single-port-write, single-port-read memory with registered read data.
module rpq_store (
   input  logic                   clock,
   input  rpq_pkg::store_req_type store_req,
   output rpq_pkg::rec_type       rd_data
);
   import rpq_pkg::*;

   rec_type mem [CAPACITY];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rpq_ctrl.sv =====
// Sequencer: insert, removal scan with swap write-back, and the result register.
module rpq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [rpq_pkg::ID_W-1:0]        req_record_id,
   input  logic [rpq_pkg::SCORE_W-1:0]     req_score,
   input  logic [rpq_pkg::CLASS_W-1:0]     req_class_code,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rpq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [rpq_pkg::ID_W-1:0]        rsp_out_id,
   output logic [rpq_pkg::SCORE_W-1:0]     rsp_out_score,
   output logic [rpq_pkg::CLASS_W-1:0]     rsp_out_class,
   output rpq_pkg::store_req_type          store_req,
   input  rpq_pkg::rec_type                rd_data
);
   import rpq_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FIRST = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_FINAL = 2'd3;

   logic [1:0]          state_ff,  state_in;
   logic [CNT_W-1:0]    head_ff,   head_in;
   logic [CNT_W-1:0]    fill_ff,   fill_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]    pend_ff,   pend_in;
   rec_type             best_ff,   best_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   rec_type             rsp_rec_ff, rsp_rec_in;

   logic out_free;
   logic req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      rsp_rec_in   = rsp_rec_ff;
      store_req    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_opcode == OP_INSERT) begin
                  rsp_valid_in = 1'b1;
                  rsp_rec_in   = '0;
                  if (fill_ff == CNT_W'(CAPACITY)) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     status_in         = ST_INSERTED;
                     store_req.wr_en   = 1'b1;
                     store_req.wr_addr = fill_ff[IDX_W-1:0];
                     store_req.wr_data = '{id: req_record_id, score: req_score,
                                           cls: req_class_code};
                     fill_in           = fill_ff + CNT_W'(1);
                  end
               end else if (head_ff == fill_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_rec_in   = '0;
                  status_in    = ST_UNDERFLOW;
               end else begin
                  store_req.rd_en   = 1'b1;
                  store_req.rd_addr = head_ff[IDX_W-1:0];
                  rd_idx_in         = head_ff + CNT_W'(1);
                  state_in          = S_FIRST;
               end
            end
         end
         S_FIRST, S_SCAN: begin
            if (state_ff == S_FIRST) begin
               best_in = rd_data;
            end else if (beats(rd_data, best_ff)) begin
               store_req.wr_en   = 1'b1;
               store_req.wr_addr = pend_ff;
               store_req.wr_data = best_ff;
               best_in           = rd_data;
            end
            if (rd_idx_ff < fill_ff) begin
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = rd_idx_ff[IDX_W-1:0];
               pend_in           = rd_idx_ff[IDX_W-1:0];
               rd_idx_in         = rd_idx_ff + CNT_W'(1);
               state_in          = S_SCAN;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               store_req.wr_en   = 1'b1;
               store_req.wr_addr = head_ff[IDX_W-1:0];
               store_req.wr_data = best_ff;
               head_in           = head_ff + CNT_W'(1);
               rsp_valid_in      = 1'b1;
               status_in         = ST_REMOVED;
               rsp_rec_in        = best_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      pend_ff    <= pend_in;
      best_ff    <= best_in;
      status_ff  <= status_in;
      rsp_rec_ff <= rsp_rec_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_id    = rsp_rec_ff.id;
   assign rsp_out_score = rsp_rec_ff.score;
   assign rsp_out_class = rsp_rec_ff.cls;

endmodule

// ===== hw/rtl/record_priority_queue.sv =====
// Top level of the record priority queue.
//
// Request channel (req_*): one transfer carries an opcode and a record.
// Insert appends the record at the tail slot; once every slot has been used
// it answers overflow. Remove answers underflow on an empty queue, else it
// returns the best record: higher score, then class 'F', then lower id.
// Slots are not reclaimed: each slot is filled at most once.
// Response channel (rsp_*): exactly one transfer per request, in order;
// status, then the removed record's fields (zero for other statuses).
// Insert, overflow and underflow answer in the cycle after the request
// transfer. A remove reads the live entries one at a time through the
// single read port, then does the final head write and loads the
// response register.
// Throughput: one request at a time; a new request transfer is taken in the
// cycle the previous response leaves or later.
// Reset empties the queue and drops any pending response.
// A stalled response holds its fields and blocks further requests.
module record_priority_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [rpq_pkg::ID_W-1:0]     req_record_id,
   input  logic [rpq_pkg::SCORE_W-1:0]  req_score,
   input  logic [rpq_pkg::CLASS_W-1:0]  req_class_code,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rpq_pkg::STATUS_W-1:0] rsp_status,
   output logic [rpq_pkg::ID_W-1:0]     rsp_out_id,
   output logic [rpq_pkg::SCORE_W-1:0]  rsp_out_score,
   output logic [rpq_pkg::CLASS_W-1:0]  rsp_out_class
);
   import rpq_pkg::*;

   store_req_type store_req;
   rec_type       rd_data;

   rpq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_record_id  (req_record_id),
      .req_score      (req_score),
      .req_class_code (req_class_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_id     (rsp_out_id),
      .rsp_out_score  (rsp_out_score),
      .rsp_out_class  (rsp_out_class),
      .store_req      (store_req),
      .rd_data        (rd_data)
   );

   rpq_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

endmodule

// ===== hw/rtl/rpq_checker.sv =====
// Port-level checks for the record priority queue, bound to the top level.
module rpq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [rpq_pkg::STATUS_W-1:0] rsp_status,
   input logic [rpq_pkg::ID_W-1:0]     rsp_out_id,
   input logic [rpq_pkg::SCORE_W-1:0]  rsp_out_score,
   input logic [rpq_pkg::CLASS_W-1:0]  rsp_out_class
);
   import rpq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response dropped or changed");

   a_req_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response is stalled");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_REMOVED) |->
         (rsp_out_id == '0) && (rsp_out_score == '0) && (rsp_out_class == '0))
      else $error("non-removal response carries record fields");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response present right after reset");

endmodule

bind record_priority_queue rpq_checker u_rpq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_out_id    (rsp_out_id),
   .rsp_out_score (rsp_out_score),
   .rsp_out_class (rsp_out_class)
);

// ===== dv/record_priority_queue_tb.sv =====
// Self-checking testbench for record_priority_queue: directed and random transfers.
`timescale 1ns / 100ps

module record_priority_queue_tb;
   import rpq_pkg::*;

   localparam int RANDOM_ITEMS = 1550;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      rec_type             rec;
   } queue_answer_type;

   class queue_scoreboard;
      rec_type          slots[CAPACITY];
      int               head_slot;
      int               filled_slots;
      queue_answer_type expected_answers[$];
      int               errors;

      function new();
         head_slot = 0;
         filled_slots = 0;
         errors = 0;
      endfunction

      function bit outranks(rec_type cand, rec_type held);
         if (cand.score > held.score) return 1'b1;
         if (cand.score < held.score) return 1'b0;
         if (cand.cls != held.cls) return cand.cls == PREFERRED_CLASS;
         return cand.id < held.id;
      endfunction

      function int outstanding();
         return expected_answers.size();
      endfunction

      function void apply_request(logic op, rec_type item);
         queue_answer_type answer;
         rec_type          best;
         rec_type          swap;
         answer.status = ST_INSERTED;
         answer.rec = '0;
         if (op == OP_INSERT) begin
            if (filled_slots >= CAPACITY) begin
               answer.status = ST_OVERFLOW;
            end else begin
               slots[filled_slots] = item;
               filled_slots++;
            end
         end else if (head_slot >= filled_slots) begin
            answer.status = ST_UNDERFLOW;
         end else begin
            best = slots[head_slot];
            for (int i = head_slot + 1; i < filled_slots; i++) begin
               if (outranks(slots[i], best)) begin
                  swap = best;
                  best = slots[i];
                  slots[i] = swap;
               end
            end
            slots[head_slot] = best;
            head_slot++;
            answer.status = ST_REMOVED;
            answer.rec = best;
         end
         expected_answers.push_back(answer);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 50) $display("mismatch: %s", what);
      endtask

      task compare_response(logic [STATUS_W-1:0] status, rec_type got);
         queue_answer_type want;
         if (expected_answers.size() == 0) begin
            report($sformatf("unexpected response status %0d", status));
            return;
         end
         want = expected_answers.pop_front();
         if (status !== want.status)
            report($sformatf("status got %0d want %0d", status, want.status));
         if (got.id !== want.rec.id)
            report($sformatf("out_id got %h want %h", got.id, want.rec.id));
         if (got.score !== want.rec.score)
            report($sformatf("out_score got %h want %h", got.score, want.rec.score));
         if (got.cls !== want.rec.cls)
            report($sformatf("out_class got %h want %h", got.cls, want.rec.cls));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_opcode = OP_INSERT;
   logic [ID_W-1:0]     req_record_id = '0;
   logic [SCORE_W-1:0]  req_score = '0;
   logic [CLASS_W-1:0]  req_class_code = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_out_id;
   logic [SCORE_W-1:0]  rsp_out_score;
   logic [CLASS_W-1:0]  rsp_out_class;

   queue_scoreboard sb = new();
   int              stall_mode = 0;
   int              phase_left = 0;

   record_priority_queue dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_record_id  (req_record_id),
      .req_score      (req_score),
      .req_class_code (req_class_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_id     (rsp_out_id),
      .rsp_out_score  (rsp_out_score),
      .rsp_out_class  (rsp_out_class)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.compare_response(rsp_status, '{id: rsp_out_id, score: rsp_out_score,
                                           cls: rsp_out_class});
      end
      if (phase_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         phase_left <= $urandom_range(20, 200);
      end else begin
         phase_left <= phase_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   task automatic send_request(logic op, rec_type item);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_record_id <= item.id;
      req_score <= item.score;
      req_class_code <= item.cls;
      do @(posedge clock); while (req_stall);
      sb.apply_request(op, item);
   endtask

   task automatic hold_off(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   function automatic rec_type random_record();
      rec_type item;
      item.id = $urandom_range(0, 3) == 0 ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
      case ($urandom_range(0, 3))
         0: item.score = '1;
         1: item.score = SCORE_W'($urandom_range(0, 2) * 100);
         default: item.score = SCORE_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0, 1: item.cls = PREFERRED_CLASS;
         2: item.cls = CLASS_W'($urandom_range(8'h45, 8'h47));
         default: item.cls = CLASS_W'($urandom);
      endcase
      return item;
   endfunction

   initial begin
      int sent;
      int burst;
      int gap;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_REMOVE, '{id: '1, score: '1, cls: '1});
      send_request(OP_INSERT, '{id: 16'hFFFF, score: 16'h0000, cls: 8'h00});
      send_request(OP_REMOVE, '{id: 16'h0000, score: 16'h0000, cls: 8'h00});
      send_request(OP_REMOVE, random_record());
      send_request(OP_INSERT, '{id: 16'h0000, score: 16'hFFFF, cls: 8'hFF});
      send_request(OP_INSERT, '{id: 16'd5, score: 16'hFFFF, cls: PREFERRED_CLASS});
      send_request(OP_INSERT, '{id: 16'd3, score: 16'hFFFF, cls: PREFERRED_CLASS});
      send_request(OP_INSERT, '{id: 16'd1, score: 16'hFFFF, cls: 8'h41});
      hold_off(3);
      send_request(OP_INSERT, '{id: 16'd9, score: 16'd100, cls: PREFERRED_CLASS});
      send_request(OP_INSERT, '{id: 16'd2, score: 16'd100, cls: 8'h47});
      repeat (4) send_request(OP_REMOVE, random_record());
      send_request(OP_INSERT, '{id: 16'd8, score: 16'd100, cls: PREFERRED_CLASS});
      repeat (4) send_request(OP_REMOVE, random_record());

      // pause until every outstanding answer is back
      drain_answers();
      hold_off(5);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 16);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            send_request(logic'($urandom_range(0, 1)), random_record());
            sent++;
         end
         if (sent == RANDOM_ITEMS / 2) drain_answers();
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) hold_off(gap);
      end

      drain_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("record_priority_queue_tb: PASS");
      end else begin
         $display("record_priority_queue_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("record_priority_queue_tb: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rpq_pkg.sv
hw/rtl/rpq_store.sv
hw/rtl/rpq_ctrl.sv
hw/rtl/record_priority_queue.sv
hw/rtl/rpq_checker.sv
dv/record_priority_queue_tb.sv
